// File: hdl/mcb_pkg.sv
// shared types and constants of the multi-channel blink controller
package mcb_pkg;

    localparam int CH_W   = 3;
    localparam int DATA_W = 8;
    localparam int OUT_W  = 8;

    localparam logic [DATA_W-1:0] EDGE_PRESET   = 8'hFE;
    localparam logic [DATA_W-1:0] FOREVER_LIMIT = 8'd100;

    typedef enum logic
    {
        OP_TICK  = 1'b0,
        OP_BLINK = 1'b1
    } mcb_op_t;

    typedef struct packed
    {
        mcb_op_t             opcode;
        logic [CH_W-1:0]     channel;
        logic [DATA_W-1:0]   repeat_count;
        logic [DATA_W-1:0]   high_ticks;
        logic [DATA_W-1:0]   low_ticks;
    } mcb_item_t;

    typedef struct packed
    {
        logic                tick;
        logic                start;
        logic [DATA_W-1:0]   repeat_count;
        logic [DATA_W-1:0]   high_ticks;
        logic [DATA_W-1:0]   low_ticks;
    } mcb_ctrl_t;

    typedef struct packed
    {
        logic                pin_next;
        logic                done;
    } mcb_stat_t;

endpackage

// File: hdl/mcb_cmd_if.sv
// command channel: tick or blink request with valid/ready handshake
interface mcb_cmd_if;
    logic                         valid;
    logic                         ready;
    mcb_pkg::mcb_op_t             opcode;
    logic [mcb_pkg::CH_W-1:0]     channel;
    logic [mcb_pkg::DATA_W-1:0]   repeat_count;
    logic [mcb_pkg::DATA_W-1:0]   high_ticks;
    logic [mcb_pkg::DATA_W-1:0]   low_ticks;

    modport source
    (
        output valid, opcode, channel, repeat_count, high_ticks, low_ticks,
        input  ready
    );

    modport sink
    (
        input  valid, opcode, channel, repeat_count, high_ticks, low_ticks,
        output ready
    );
endinterface

// File: hdl/mcb_res_if.sv
// result channel: pin levels and finished flags with valid/ready handshake
interface mcb_res_if;
    logic                         valid;
    logic                         ready;
    logic [mcb_pkg::OUT_W-1:0]    pin_levels;
    logic [mcb_pkg::OUT_W-1:0]    finished;

    modport source
    (
        output valid, pin_levels, finished,
        input  ready
    );

    modport sink
    (
        input  valid, pin_levels, finished,
        output ready
    );
endinterface

// File: hdl/mcb_channel.sv
// state and update logic of one blinking channel
module mcb_channel
(
    input  logic               clk,
    input  logic               rst_n,
    input  mcb_pkg::mcb_ctrl_t ctrl,
    output mcb_pkg::mcb_stat_t stat
);
    import mcb_pkg::*;

    logic              pin_reg;
    logic              pin_next;
    logic [DATA_W-1:0] edge_reg;
    logic [DATA_W-1:0] edge_next;
    logic [DATA_W-1:0] toggles_reg;
    logic [DATA_W-1:0] toggles_next;
    logic              forever_reg;
    logic              forever_next;
    logic [DATA_W-1:0] high_reg;
    logic [DATA_W-1:0] low_reg;
    logic [DATA_W-1:0] edge_inc;
    logic [DATA_W-1:0] limit;
    logic              active;
    logic              done;

    assign active   = forever_reg || (toggles_reg != '0);
    assign edge_inc = edge_reg + DATA_W'(1);
    assign limit    = pin_reg ? high_reg : low_reg;

    always_comb
    begin
        pin_next     = pin_reg;
        edge_next    = edge_reg;
        toggles_next = toggles_reg;
        forever_next = forever_reg;
        done         = 1'b0;
        if (ctrl.start)
        begin
            pin_next  = 1'b0;
            edge_next = EDGE_PRESET;
            if (ctrl.repeat_count > FOREVER_LIMIT)
            begin
                forever_next = 1'b1;
                toggles_next = '0;
            end
            else
            begin
                forever_next = 1'b0;
                toggles_next = {ctrl.repeat_count[DATA_W-2:0], 1'b0};
            end
        end
        else if (ctrl.tick && active)
        begin
            if (edge_inc > limit)
            begin
                edge_next = DATA_W'(1);
                pin_next  = ~pin_reg;
                if (!forever_reg)
                begin
                    toggles_next = toggles_reg - DATA_W'(1);
                    done         = (toggles_reg == DATA_W'(1));
                end
            end
            else
            begin
                edge_next = edge_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pin_reg     <= 1'b0;
            edge_reg    <= '0;
            toggles_reg <= '0;
            forever_reg <= 1'b0;
        end
        else
        begin
            pin_reg     <= pin_next;
            edge_reg    <= edge_next;
            toggles_reg <= toggles_next;
            forever_reg <= forever_next;
        end
    end

    // durations, written by a blink command only
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            high_reg <= ctrl.high_ticks;
            low_reg  <= ctrl.low_ticks;
        end
    end

    assign stat.pin_next = pin_next;
    assign stat.done     = done;

    a_start_preset: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.start |=> (edge_reg == EDGE_PRESET) && !pin_reg)
        else $error("blink command did not preset channel");

    a_forever_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        forever_reg |-> (toggles_reg == '0))
        else $error("endless channel holds a toggle count");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (toggles_reg == '0) && !forever_reg)
        else $error("channel reported done but remains armed");
endmodule

// File: hdl/multi_channel_blink_controller_top.sv
// top level of the multi-channel blink controller
// One transfer in, one transfer out: every command (a tick for all channels or a
// blink request for one channel) yields one result with the pin levels after it and
// the channels that completed their counted blinks. A command is taken every cycle
// while results are taken. A command is first held in the input register. The
// channel registers are then updated in a single pass, and the result register is
// loaded at the same edge, from where the result is presented until it is taken.
// Channels at or above eight are updated by ticks but not reported; blink requests
// address channels 0 to 7 only.
module multi_channel_blink_controller_top
#(
    parameter int CHANNELS = 8
)
(
    input  logic      clk,
    input  logic      rst_n,
    mcb_cmd_if.sink   cmd,
    mcb_res_if.source res
);
    import mcb_pkg::*;

    localparam int ADDRESSABLE = 1 << CH_W;

    logic                s1_valid_reg;
    mcb_item_t           s1_item_reg;
    logic                res_valid_reg;
    logic [OUT_W-1:0]    res_pin_reg;
    logic [OUT_W-1:0]    res_fin_reg;
    logic                advance;
    logic                load;
    logic                go;
    logic [CHANNELS-1:0] sel;
    mcb_ctrl_t           ctrl [CHANNELS];
    mcb_stat_t           stat [CHANNELS];
    logic [OUT_W-1:0]    pin_shown;
    logic [OUT_W-1:0]    fin_shown;

    assign advance   = !res_valid_reg || res.ready;
    assign cmd.ready = !s1_valid_reg || advance;
    assign load      = cmd.valid && cmd.ready;
    assign go        = s1_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.ready)
            begin
                s1_valid_reg <= cmd.valid;
            end
            if (advance)
            begin
                res_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_item_reg.opcode       <= cmd.opcode;
            s1_item_reg.channel      <= cmd.channel;
            s1_item_reg.repeat_count <= cmd.repeat_count;
            s1_item_reg.high_ticks   <= cmd.high_ticks;
            s1_item_reg.low_ticks    <= cmd.low_ticks;
        end
        if (go)
        begin
            res_pin_reg <= pin_shown;
            res_fin_reg <= fin_shown;
        end
    end

    genvar i;
    generate
        for (i = 0; i < CHANNELS; i++)
        begin : g_chan
            if (i < ADDRESSABLE)
            begin : g_sel
                assign sel[i] = (s1_item_reg.channel == CH_W'(i));
            end
            else
            begin : g_nosel
                assign sel[i] = 1'b0;
            end

            assign ctrl[i].tick         = go && (s1_item_reg.opcode == OP_TICK);
            assign ctrl[i].start        = go && (s1_item_reg.opcode == OP_BLINK) && sel[i];
            assign ctrl[i].repeat_count = s1_item_reg.repeat_count;
            assign ctrl[i].high_ticks   = s1_item_reg.high_ticks;
            assign ctrl[i].low_ticks    = s1_item_reg.low_ticks;

            mcb_channel u_channel
            (
                .clk   (clk),
                .rst_n (rst_n),
                .ctrl  (ctrl[i]),
                .stat  (stat[i])
            );
        end

        for (i = 0; i < OUT_W; i++)
        begin : g_out
            if (i < CHANNELS)
            begin : g_used
                assign pin_shown[i] = stat[i].pin_next;
                assign fin_shown[i] = stat[i].done;
            end
            else
            begin : g_unused
                assign pin_shown[i] = 1'b0;
                assign fin_shown[i] = 1'b0;
            end
        end
    endgenerate

    assign res.valid      = res_valid_reg;
    assign res.pin_levels = res_pin_reg;
    assign res.finished   = res_fin_reg;

    a_blink_no_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (go && (s1_item_reg.opcode == OP_BLINK)) |=> (res_fin_reg == '0))
        else $error("blink command result reports finished channels");

    a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> cmd.ready)
        else $error("empty input register refuses a transfer");

    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res.ready && s1_valid_reg) |-> !cmd.ready)
        else $error("transfer taken while pipeline is full and stalled");
endmodule

// File: tb/mcb_result_checker.sv
// checker for the blink controller: predicts each result from the accepted commands and compares
module mcb_result_checker
#(
    parameter int CHANNELS = 8
)
(
    input  logic clk,
    input  logic rst_n,
    mcb_cmd_if   cmd,
    mcb_res_if   res,
    output int   fail_cnt,
    output int   pending,
    output int   blink_cnt,
    output int   result_cnt,
    output int   finish_cnt
);
    import mcb_pkg::*;

    typedef struct packed
    {
        logic [OUT_W-1:0] pins;
        logic [OUT_W-1:0] done;
    } pin_report_t;

    logic              pin_on       [CHANNELS];
    logic [DATA_W-1:0] edge_cnt     [CHANNELS];
    logic [DATA_W-1:0] toggles_left [CHANNELS];
    logic [DATA_W-1:0] high_dur     [CHANNELS];
    logic [DATA_W-1:0] low_dur      [CHANNELS];
    logic              blink_endless [CHANNELS];
    pin_report_t       pin_reports_q [$];

    int fails;
    int blinks;
    int results;
    int finishes;

    function automatic pin_report_t advance_pins(input mcb_item_t c);
        pin_report_t       rep;
        logic [DATA_W-1:0] limit;
        rep = '0;
        if (c.opcode == OP_BLINK)
        begin
            if (int'(c.channel) < CHANNELS)
            begin
                pin_on[c.channel]   = 1'b0;
                edge_cnt[c.channel] = EDGE_PRESET;
                if (c.repeat_count > FOREVER_LIMIT)
                begin
                    blink_endless[c.channel] = 1'b1;
                    toggles_left[c.channel]  = '0;
                end
                else
                begin
                    blink_endless[c.channel] = 1'b0;
                    toggles_left[c.channel]  = DATA_W'(c.repeat_count << 1);
                end
                high_dur[c.channel] = c.high_ticks;
                low_dur[c.channel]  = c.low_ticks;
            end
        end
        else
        begin
            for (int n = 0; n < CHANNELS; n++)
            begin
                if (blink_endless[n] || toggles_left[n] != '0)
                begin
                    edge_cnt[n] = edge_cnt[n] + 1'b1;
                    limit = pin_on[n] ? high_dur[n] : low_dur[n];
                    if (edge_cnt[n] > limit)
                    begin
                        edge_cnt[n] = 8'd1;
                        pin_on[n]   = ~pin_on[n];
                        if (!blink_endless[n])
                        begin
                            toggles_left[n] = toggles_left[n] - 1'b1;
                            if (toggles_left[n] == '0 && n < OUT_W)
                                rep.done[n] = 1'b1;
                        end
                    end
                end
            end
        end
        for (int n = 0; n < CHANNELS && n < OUT_W; n++)
            rep.pins[n] = pin_on[n];
        return rep;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pin_report_t want;
        mcb_item_t   c;
        if (!rst_n)
        begin
            for (int n = 0; n < CHANNELS; n++)
            begin
                pin_on[n]        = 1'b0;
                edge_cnt[n]      = '0;
                toggles_left[n]  = '0;
                high_dur[n]      = '0;
                low_dur[n]       = '0;
                blink_endless[n] = 1'b0;
            end
            pin_reports_q.delete();
            fails    = 0;
            blinks   = 0;
            results  = 0;
            finishes = 0;
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                results++;
                if (pin_reports_q.size() == 0)
                begin
                    $display("%0t: result with no command outstanding: pin_levels %h finished %h",
                             $time, res.pin_levels, res.finished);
                    fails++;
                end
                else
                begin
                    want = pin_reports_q.pop_front();
                    if (res.pin_levels !== want.pins)
                    begin
                        $display("%0t: pin_levels mismatch, expected %h actual %h",
                                 $time, want.pins, res.pin_levels);
                        fails++;
                    end
                    if (res.finished !== want.done)
                    begin
                        $display("%0t: finished mismatch, expected %h actual %h",
                                 $time, want.done, res.finished);
                        fails++;
                    end
                end
            end
            if (cmd.valid && cmd.ready)
            begin
                c.opcode       = cmd.opcode;
                c.channel      = cmd.channel;
                c.repeat_count = cmd.repeat_count;
                c.high_ticks   = cmd.high_ticks;
                c.low_ticks    = cmd.low_ticks;
                want = advance_pins(c);
                pin_reports_q.push_back(want);
                if (c.opcode == OP_BLINK)
                    blinks++;
                finishes += $countones(want.done);
            end
        end
        fail_cnt   <= fails;
        pending    <= pin_reports_q.size();
        blink_cnt  <= blinks;
        result_cnt <= results;
        finish_cnt <= finishes;
    end

endmodule

// File: tb/multi_channel_blink_controller_top_tb.sv
// stimulus and verdict for the multi-channel blink controller testbench
module multi_channel_blink_controller_top_tb;
    import mcb_pkg::*;

    localparam int CHANNELS    = 8;
    localparam int HOLD_CYCLES = 300;

    typedef enum
    {
        PH_DIRECT,
        PH_FREE,
        PH_SRC_IDLE,
        PH_SINK_STALL,
        PH_BOTH,
        PH_HOLD
    } tb_phase_t;

    logic      clk;
    logic      rst_n;
    tb_phase_t phase;
    int        src_idle;
    int        sink_stall;
    int        fail_cnt;
    int        pending;
    int        blink_cnt;
    int        result_cnt;
    int        finish_cnt;

    mcb_cmd_if cmd_ch ();
    mcb_res_if res_ch ();

    multi_channel_blink_controller_top
    #(
        .CHANNELS(CHANNELS)
    )
    dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    mcb_result_checker
    #(
        .CHANNELS(CHANNELS)
    )
    result_chk
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd_ch),
        .res        (res_ch),
        .fail_cnt   (fail_cnt),
        .pending    (pending),
        .blink_cnt  (blink_cnt),
        .result_cnt (result_cnt),
        .finish_cnt (finish_cnt)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic mcb_item_t tick_cmd();
        mcb_item_t c;
        c.opcode       = OP_TICK;
        c.channel      = CH_W'($urandom);
        c.repeat_count = DATA_W'($urandom);
        c.high_ticks   = DATA_W'($urandom);
        c.low_ticks    = DATA_W'($urandom);
        return c;
    endfunction

    function automatic mcb_item_t blink_cmd(input int ch, input int cnt, input int hi,
                                            input int lo);
        mcb_item_t c;
        c.opcode       = OP_BLINK;
        c.channel      = CH_W'(ch);
        c.repeat_count = DATA_W'(cnt);
        c.high_ticks   = DATA_W'(hi);
        c.low_ticks    = DATA_W'(lo);
        return c;
    endfunction

    // mostly ticks, blinks with short periods so that channels finish often
    function automatic mcb_item_t random_cmd();
        mcb_item_t c;
        int        pick;
        c = tick_cmd();
        if ($urandom_range(99) < 15)
        begin
            c.opcode = OP_BLINK;
            pick = $urandom_range(99);
            if (pick < 55)
                c.repeat_count = DATA_W'($urandom_range(4, 1));
            else if (pick < 70)
                c.repeat_count = DATA_W'($urandom_range(100, 5));
            else if (pick < 88)
                c.repeat_count = DATA_W'($urandom_range(255, 101));
            else
                c.repeat_count = '0;
            if ($urandom_range(99) < 80)
            begin
                c.high_ticks = DATA_W'($urandom_range(3));
                c.low_ticks  = DATA_W'($urandom_range(3));
            end
        end
        return c;
    endfunction

    task automatic set_phase(input tb_phase_t p, input int src, input int sink);
        phase      <= p;
        sink_stall <= sink;
        src_idle    = src;
    endtask

    // valid stays high across back-to-back transfers
    task automatic send(input mcb_item_t c);
        while ($urandom_range(99) < src_idle)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid        <= 1'b1;
        cmd_ch.opcode       <= c.opcode;
        cmd_ch.channel      <= c.channel;
        cmd_ch.repeat_count <= c.repeat_count;
        cmd_ch.high_ticks   <= c.high_ticks;
        cmd_ch.low_ticks    <= c.low_ticks;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
    endtask

    task automatic drain();
        cmd_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic send_random(input int n);
        repeat (n)
            send(random_cmd());
    endtask

    initial
    begin
        rst_n               <= 1'b0;
        cmd_ch.valid        <= 1'b0;
        cmd_ch.opcode       <= OP_TICK;
        cmd_ch.channel      <= '0;
        cmd_ch.repeat_count <= '0;
        cmd_ch.high_ticks   <= '0;
        cmd_ch.low_ticks    <= '0;
        set_phase(PH_DIRECT, 0, 0);
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(tick_cmd());
        send(blink_cmd(0, 1, 0, 0));
        send(blink_cmd(7, 255, 1, 0));
        send(blink_cmd(1, 0, 255, 255));
        send(blink_cmd(2, 100, 255, 255));
        send(blink_cmd(3, 101, 0, 255));
        send(blink_cmd(4, 2, 2, 1));
        repeat (8)
            send(tick_cmd());
        // stop an endless channel, then odd bit patterns
        send(blink_cmd(7, 0, 0, 0));
        send(blink_cmd(5, 1, 254, 254));
        send(blink_cmd(6, 128, 170, 85));
        repeat (7)
            send(tick_cmd());
        drain();

        set_phase(PH_FREE, 0, 0);
        send_random(150);
        set_phase(PH_SRC_IDLE, 64, 0);
        send_random(150);
        drain();
        set_phase(PH_SINK_STALL, 0, 64);
        send_random(150);
        set_phase(PH_BOTH, 35, 35);
        send_random(150);
        drain();
        set_phase(PH_HOLD, 0, 0);
        send_random(60);
        drain();
        set_phase(PH_FREE, 0, 0);
        send_random(100);
        drain();
        repeat (8)
            @(posedge clk);

        $display("covered %0d commands (%0d blink requests) with %0d channel completions",
                 result_cnt, blink_cnt, finish_cnt);
        $display("idle and stall mixes on both sides, including a long result hold-off");
        if (fail_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // result side: random stalls per phase, one long hold-off to back the block up
    initial
    begin
        bit hold_done;
        hold_done = 1'b0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (phase == PH_HOLD && !hold_done)
            begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES)
                    @(posedge clk);
                hold_done = 1'b1;
            end
            res_ch.ready <= ($urandom_range(99) >= sink_stall);
        end
    end

endmodule

// File: filelist.f
hdl/mcb_pkg.sv
hdl/mcb_cmd_if.sv
hdl/mcb_res_if.sv
hdl/mcb_channel.sv
hdl/multi_channel_blink_controller_top.sv
tb/mcb_result_checker.sv
tb/multi_channel_blink_controller_top_tb.sv
